FILE: sv/cte_pkg.sv
// Package for the cube texel to equirectangular sample block.
// Widths, face and register codes, pipeline stage types and the arctangent table.
// No dependencies.
package cte_pkg;

   localparam int FACE_SIZE_W  = 13;
   localparam int SRC_SIZE_W   = 14;
   localparam int FACE_SEL_W   = 3;
   localparam int TEX_W        = 12;
   localparam int COORD_W      = 13;
   localparam int FRAC_BITS    = 16;
   localparam int WORK_BITS    = 29;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 14;

   localparam logic [FACE_SIZE_W-1:0] MAX_FACE_SIZE = 13'd4096;
   localparam logic [SRC_SIZE_W-1:0]  MAX_SRC_SIZE  = 14'd8192;

   localparam logic [FACE_SIZE_W-1:0] FACE_SIZE_RESET  = 13'd512;
   localparam logic [SRC_SIZE_W-1:0]  SRC_WIDTH_RESET  = 14'd1024;
   localparam logic [SRC_SIZE_W-1:0]  SRC_HEIGHT_RESET = 14'd512;

   localparam logic [CSR_IDX_W-1:0] CSR_FACE_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd2;

   localparam logic [FACE_SEL_W-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_SEL_W-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_SEL_W-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_SEL_W-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_SEL_W-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_SEL_W-1:0] FACE_NEG_Z = 3'd5;

   // divider: (2t+1) << FRAC_BITS, one quotient bit per cell
   localparam int REM_W     = FACE_SIZE_W;
   localparam int NUM_W     = TEX_W + 1 + FRAC_BITS;
   localparam int DIV_STEPS = NUM_W;
   localparam int COMP_W    = FRAC_BITS + 2;
   localparam int ONE_Q     = 1 << FRAC_BITS;
   localparam int COMP_MAX  = (2 << FRAC_BITS) - 1;

   // square root of (dx^2 + dz^2) << 2(WORK_BITS-FRAC_BITS), two radicand bits per cell
   localparam int SQ_W       = 2 * COMP_W - 1;
   localparam int SQ_SHIFT   = 2 * (WORK_BITS - FRAC_BITS);
   localparam int RAD_W      = SQ_W + SQ_SHIFT + 1;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int SREM_W     = ROOT_W + 3;
   localparam int SQRT_STEPS = ROOT_W;

   // CORDIC vectoring
   localparam int CORDIC_STEPS = 32;
   localparam int STEP_W       = 5;
   localparam int CV_W         = 34;
   localparam int ANG_W        = 36;
   localparam longint PI_Q32   = 64'sd13493037705;
   localparam logic signed [ANG_W-1:0] HALF_PI    = ANG_W'(PI_Q32 / 2);
   localparam logic signed [ANG_W-1:0] QUARTER_PI = ANG_W'(PI_Q32 / 4);
   localparam int INV_W        = 29;
   localparam logic [INV_W-1:0] INV_PI_Q30 = 29'd341782638;

   // 2^62 / (2k+1), floored, for the arctangent series
   localparam longint Q62 = longint'(1) << 62;
   localparam longint ODD_RECIP [31] = '{
      Q62 / 1,  Q62 / 3,  Q62 / 5,  Q62 / 7,  Q62 / 9,  Q62 / 11, Q62 / 13, Q62 / 15,
      Q62 / 17, Q62 / 19, Q62 / 21, Q62 / 23, Q62 / 25, Q62 / 27, Q62 / 29, Q62 / 31,
      Q62 / 33, Q62 / 35, Q62 / 37, Q62 / 39, Q62 / 41, Q62 / 43, Q62 / 45, Q62 / 47,
      Q62 / 49, Q62 / 51, Q62 / 53, Q62 / 55, Q62 / 57, Q62 / 59, Q62 / 61
   };

   typedef logic signed [ANG_W-1:0] atan_table_type [CORDIC_STEPS];

   function automatic atan_table_type build_atan_table();
      atan_table_type tbl;
      longint acc;
      longint term;
      int i;
      int k;
      for (i = 0; i < CORDIC_STEPS; i++) begin
         acc = 0;
         if (i == 0) begin
            tbl[i] = QUARTER_PI;
         end else begin
            for (k = 0; i * (2 * k + 1) <= 62; k++) begin
               term = ODD_RECIP[k] >>> (i * (2 * k + 1));
               if (k[0]) acc = acc - term;
               else acc = acc + term;
            end
            tbl[i] = ANG_W'((acc + (longint'(1) << 29)) >>> 30);
         end
      end
      return tbl;
   endfunction

   localparam atan_table_type ATAN_TABLE = build_atan_table();

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [NUM_W-1:0] num;
      logic [NUM_W-1:0] quo;
   } div_lane_type;

   typedef struct packed {
      logic [FACE_SEL_W-1:0] face;
      div_lane_type          a;
      div_lane_type          b;
   } div_stage_type;

   typedef struct packed {
      logic [RAD_W-1:0]         rad;
      logic [SREM_W-1:0]        rem;
      logic [ROOT_W-1:0]        root;
      logic signed [COMP_W-1:0] dx;
      logic signed [COMP_W-1:0] dy;
      logic signed [COMP_W-1:0] dz;
      logic                     dir_ok;
   } sqrt_stage_type;

   typedef struct packed {
      logic signed [CV_W-1:0]  x;
      logic signed [CV_W-1:0]  y;
      logic signed [ANG_W-1:0] z;
   } cordic_lane_type;

   typedef struct packed {
      cordic_lane_type lon;
      cordic_lane_type lat;
      logic            dir_ok;
   } cordic_stage_type;

endpackage

FILE: sv/cte_if.sv
// Channel interfaces: request, response and CSR write.
// Depends on cte_pkg.
interface cte_req_if import cte_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [FACE_SEL_W-1:0] face;
   logic [TEX_W-1:0]      texel_x;
   logic [TEX_W-1:0]      texel_y;
   modport source (output valid, face, texel_x, texel_y, input ready);
   modport sink   (input valid, face, texel_x, texel_y, output ready);
endinterface

interface cte_rsp_if import cte_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [COORD_W-1:0]   col_left;
   logic [COORD_W-1:0]   col_right;
   logic [COORD_W-1:0]   row_top;
   logic [COORD_W-1:0]   row_bottom;
   logic [FRAC_BITS-1:0] frac_x;
   logic [FRAC_BITS-1:0] frac_y;
   modport source (output valid, col_left, col_right, row_top, row_bottom, frac_x, frac_y,
                   input ready);
   modport sink   (input valid, col_left, col_right, row_top, row_bottom, frac_x, frac_y,
                   output ready);
endinterface

interface cte_csr_if import cte_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/cube_texel_to_equirect_sample_top.sv
// Top level: cube texel to equirectangular bilinear sample position.
// Depends on cte_pkg, cte_if, cte_div_cell, cte_sqrt_cell, cte_cordic_cell.
//
//   channel  dir  payload                                          accepted when
//   req      in   face, texel_x, texel_y                           valid && ready
//   rsp      out  col_left/right, row_top/bottom, frac_x/frac_y    valid && ready
//   csr      in   index, data                                      valid (ready tied high)
//
// One request per cycle while the pipeline is not stalled; it has 29 divider
// cells, 31 square root cells and 32 CORDIC cells plus seven register stages.
// Reset clears all valid flags and loads the register defaults.
// A response held by rsp.ready low freezes the whole pipeline and drops req.ready.
module cube_texel_to_equirect_sample_top import cte_pkg::*; (
   input logic       clock,
   input logic       reset,
   cte_req_if.sink   req,
   cte_rsp_if.source rsp,
   cte_csr_if.sink   csr
);

   logic [FACE_SIZE_W-1:0] face_size_ff;
   logic [SRC_SIZE_W-1:0]  src_width_ff;
   logic [SRC_SIZE_W-1:0]  src_height_ff;
   logic [FACE_SIZE_W-1:0] n_clamp;
   logic [SRC_SIZE_W-1:0]  w_clamp;
   logic [SRC_SIZE_W-1:0]  h_clamp;
   logic                   en;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         face_size_ff  <= FACE_SIZE_RESET;
         src_width_ff  <= SRC_WIDTH_RESET;
         src_height_ff <= SRC_HEIGHT_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_FACE_SIZE:  face_size_ff  <= csr.data[FACE_SIZE_W-1:0];
            CSR_SRC_WIDTH:  src_width_ff  <= csr.data;
            CSR_SRC_HEIGHT: src_height_ff <= csr.data;
            default: ;
         endcase
      end
   end
   assign csr.ready = 1'b1;

   always_comb begin
      n_clamp = face_size_ff;
      if (face_size_ff == '0) n_clamp = FACE_SIZE_W'(1);
      else if (face_size_ff > MAX_FACE_SIZE) n_clamp = MAX_FACE_SIZE;
      w_clamp = src_width_ff;
      if (src_width_ff == '0) w_clamp = SRC_SIZE_W'(1);
      else if (src_width_ff > MAX_SRC_SIZE) w_clamp = MAX_SRC_SIZE;
      h_clamp = src_height_ff;
      if (src_height_ff == '0) h_clamp = SRC_SIZE_W'(1);
      else if (src_height_ff > MAX_SRC_SIZE) h_clamp = MAX_SRC_SIZE;
   end

   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   // divider chain
   logic          div_valid [DIV_STEPS+1];
   div_stage_type div_stage [DIV_STEPS+1];

   always_comb begin
      div_valid[0]          = req.valid;
      div_stage[0].face     = req.face;
      div_stage[0].a.rem    = '0;
      div_stage[0].a.num    = {req.texel_x, 1'b1, FRAC_BITS'(0)};
      div_stage[0].a.quo    = '0;
      div_stage[0].b.rem    = '0;
      div_stage[0].b.num    = {req.texel_y, 1'b1, FRAC_BITS'(0)};
      div_stage[0].b.quo    = '0;
   end

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      cte_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .divisor   (n_clamp),
         .in_valid  (div_valid[g]),
         .in_stage  (div_stage[g]),
         .out_valid (div_valid[g+1]),
         .out_stage (div_stage[g+1])
      );
   end

   // component, face swizzle
   function automatic logic signed [COMP_W-1:0] component(logic [NUM_W-1:0] quo);
      logic signed [NUM_W+1:0] q;
      q = $signed({2'b00, quo}) - $signed((NUM_W+2)'(ONE_Q));
      if (q > $signed((NUM_W+2)'(COMP_MAX))) q = $signed((NUM_W+2)'(COMP_MAX));
      return q[COMP_W-1:0];
   endfunction

   localparam logic signed [COMP_W-1:0] ONE_C = COMP_W'(ONE_Q);

   logic                     swz_valid_ff;
   logic signed [COMP_W-1:0] swz_dx_ff, swz_dy_ff, swz_dz_ff;
   logic                     swz_ok_ff;
   logic signed [COMP_W-1:0] swz_dx_in, swz_dy_in, swz_dz_in;
   logic                     swz_ok_in;
   logic signed [COMP_W-1:0] comp_a, comp_b;

   always_comb begin
      comp_a    = component(div_stage[DIV_STEPS].a.quo);
      comp_b    = component(div_stage[DIV_STEPS].b.quo);
      swz_ok_in = 1'b1;
      swz_dx_in = '0;
      swz_dy_in = '0;
      swz_dz_in = '0;
      case (div_stage[DIV_STEPS].face)
         FACE_POS_X: begin
            swz_dx_in = ONE_C;  swz_dy_in = -comp_a; swz_dz_in = -comp_b;
         end
         FACE_NEG_X: begin
            swz_dx_in = -ONE_C; swz_dy_in = comp_a;  swz_dz_in = -comp_b;
         end
         FACE_POS_Y: begin
            swz_dx_in = comp_a; swz_dy_in = comp_b;  swz_dz_in = ONE_C;
         end
         FACE_NEG_Y: begin
            swz_dx_in = comp_a; swz_dy_in = -comp_b; swz_dz_in = -ONE_C;
         end
         FACE_POS_Z: begin
            swz_dx_in = comp_a; swz_dy_in = ONE_C;   swz_dz_in = -comp_b;
         end
         FACE_NEG_Z: begin
            swz_dx_in = -comp_a; swz_dy_in = -ONE_C; swz_dz_in = -comp_b;
         end
         default: begin
            swz_ok_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         swz_valid_ff <= 1'b0;
      end else if (en) begin
         swz_valid_ff <= div_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         swz_dx_ff <= swz_dx_in;
         swz_dy_ff <= swz_dy_in;
         swz_dz_ff <= swz_dz_in;
         swz_ok_ff <= swz_ok_in;
      end
   end

   // squared horizontal magnitude
   logic                       sqrt_valid [SQRT_STEPS+1];
   sqrt_stage_type             sqrt_stage [SQRT_STEPS+1];
   logic                       sq_valid_ff;
   sqrt_stage_type             sq_stage_ff;
   sqrt_stage_type             sq_stage_in;
   logic signed [2*COMP_W-1:0] sq_x, sq_z;
   logic [2*COMP_W:0]          sq_sum;

   always_comb begin
      sq_x   = swz_dx_ff * swz_dx_ff;
      sq_z   = swz_dz_ff * swz_dz_ff;
      sq_sum = {1'b0, sq_x} + {1'b0, sq_z};
      sq_stage_in.rad    = {1'b0, sq_sum[SQ_W-1:0], SQ_SHIFT'(0)};
      sq_stage_in.rem    = '0;
      sq_stage_in.root   = '0;
      sq_stage_in.dx     = swz_dx_ff;
      sq_stage_in.dy     = swz_dy_ff;
      sq_stage_in.dz     = swz_dz_ff;
      sq_stage_in.dir_ok = swz_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (en) begin
         sq_valid_ff <= swz_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_stage_ff <= sq_stage_in;
      end
   end

   assign sqrt_valid[0] = sq_valid_ff;
   assign sqrt_stage[0] = sq_stage_ff;

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      cte_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sqrt_valid[g]),
         .in_stage  (sqrt_stage[g]),
         .out_valid (sqrt_valid[g+1]),
         .out_stage (sqrt_stage[g+1])
      );
   end

   // CORDIC operands and pre-rotation into the right half plane
   function automatic logic signed [CV_W-1:0] scale_work(logic signed [COMP_W-1:0] v);
      logic signed [CV_W-1:0] r;
      r = CV_W'(v);
      return r <<< (WORK_BITS - FRAC_BITS);
   endfunction

   function automatic cordic_lane_type prerotate(logic signed [CV_W-1:0] y,
                                                 logic signed [CV_W-1:0] x);
      cordic_lane_type r;
      r.x = x;
      r.y = y;
      r.z = '0;
      if (x < 0) begin
         if (y >= 0) begin
            r.x = y;
            r.y = -x;
            r.z = HALF_PI;
         end else begin
            r.x = -y;
            r.y = x;
            r.z = -HALF_PI;
         end
      end
      return r;
   endfunction

   logic             cord_valid [CORDIC_STEPS+1];
   cordic_stage_type cord_stage [CORDIC_STEPS+1];
   logic             pre_valid_ff;
   cordic_stage_type pre_stage_ff;
   cordic_stage_type pre_stage_in;

   always_comb begin
      pre_stage_in.lon    = prerotate(scale_work(sqrt_stage[SQRT_STEPS].dx),
                                      -scale_work(sqrt_stage[SQRT_STEPS].dz));
      pre_stage_in.lat    = prerotate(CV_W'(sqrt_stage[SQRT_STEPS].root),
                                      scale_work(sqrt_stage[SQRT_STEPS].dy));
      pre_stage_in.dir_ok = sqrt_stage[SQRT_STEPS].dir_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (en) begin
         pre_valid_ff <= sqrt_valid[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_stage_ff <= pre_stage_in;
      end
   end

   assign cord_valid[0] = pre_valid_ff;
   assign cord_stage[0] = pre_stage_ff;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      cte_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .step      (STEP_W'(g)),
         .in_valid  (cord_valid[g]),
         .in_stage  (cord_stage[g]),
         .out_valid (cord_valid[g+1]),
         .out_stage (cord_stage[g+1])
      );
   end

   // angle to half turns: two partial products, then sum and shift
   localparam int PLO_W = 18;
   localparam int PHI_W = ANG_W - PLO_W;
   localparam int PP_LO_W = PLO_W + INV_W;
   localparam int PP_HI_W = PHI_W + INV_W + 1;
   localparam int PROD_W = PP_HI_W + PLO_W;

   logic                      m1_valid_ff;
   logic                      m1_ok_ff;
   logic [PP_LO_W-1:0]        m1_lon_lo_ff, m1_lat_lo_ff;
   logic signed [PP_HI_W-1:0] m1_lon_hi_ff, m1_lat_hi_ff;
   logic signed [INV_W:0]     inv_s;

   assign inv_s = $signed({1'b0, INV_PI_Q30});

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= cord_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ok_ff     <= cord_stage[CORDIC_STEPS].dir_ok;
         m1_lon_lo_ff <= cord_stage[CORDIC_STEPS].lon.z[PLO_W-1:0] * INV_PI_Q30;
         m1_lat_lo_ff <= cord_stage[CORDIC_STEPS].lat.z[PLO_W-1:0] * INV_PI_Q30;
         m1_lon_hi_ff <= $signed(cord_stage[CORDIC_STEPS].lon.z[ANG_W-1:PLO_W]) * inv_s;
         m1_lat_hi_ff <= $signed(cord_stage[CORDIC_STEPS].lat.z[ANG_W-1:PLO_W]) * inv_s;
      end
   end

   function automatic logic signed [ANG_W-1:0] half_turns(logic signed [PP_HI_W-1:0] hi,
                                                          logic [PP_LO_W-1:0] lo);
      logic signed [PROD_W-1:0] p;
      p = $signed({hi, PLO_W'(0)}) + $signed(PROD_W'(lo));
      return ANG_W'(p >>> 30);
   endfunction

   localparam logic signed [ANG_W-1:0] INVALID_LON = ANG_W'(64'sd1 << 32);
   localparam logic signed [ANG_W-1:0] INVALID_LAT = ANG_W'(64'sd1 << 31);

   logic                    m2_valid_ff;
   logic signed [ANG_W-1:0] m2_lon_ff, m2_lat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (en) begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m2_lon_ff <= m1_ok_ff ? half_turns(m1_lon_hi_ff, m1_lon_lo_ff) : INVALID_LON;
         m2_lat_ff <= m1_ok_ff ? half_turns(m1_lat_hi_ff, m1_lat_lo_ff) : INVALID_LAT;
      end
   end

   // source positions
   localparam int XQ_W = ANG_W + 1 + SRC_SIZE_W + 1;
   localparam int YQ_W = ANG_W + SRC_SIZE_W + 1;
   localparam int POS_W = 19;

   logic                     m3_valid_ff;
   logic signed [XQ_W-1:0]   m3_xq_ff;
   logic signed [YQ_W-1:0]   m3_yq_ff;
   logic signed [ANG_W:0]    lon_off;
   logic signed [SRC_SIZE_W:0] w_s, h_s;

   assign lon_off = $signed((ANG_W+1)'(m2_lon_ff)) + $signed((ANG_W+1)'(64'sd1 << 32));
   assign w_s     = $signed({1'b0, w_clamp});
   assign h_s     = $signed({1'b0, h_clamp});

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_valid_ff <= 1'b0;
      end else if (en) begin
         m3_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m3_xq_ff <= lon_off * w_s;
         m3_yq_ff <= m2_lat_ff * h_s;
      end
   end

   // corners and fractions
   logic signed [POS_W-1:0] c0, c1, c0m, c1m, r0, r1, r0c, r1c, wx, hx;
   logic [COORD_W-1:0]      col_left_in, col_right_in, row_top_in, row_bottom_in;

   always_comb begin
      wx = POS_W'(w_s);
      hx = POS_W'(h_s) - POS_W'(1);
      c0 = m3_xq_ff[XQ_W-1 -: POS_W];
      c1 = c0 + POS_W'(1);
      if (c0 < 0) c0m = c0 + wx;
      else if (c0 >= wx) c0m = c0 - wx;
      else c0m = c0;
      if (c1 >= wx) c1m = c1 - wx;
      else c1m = c1;
      if (w_clamp == SRC_SIZE_W'(1)) begin
         c0m = '0;
         c1m = '0;
      end
      r0 = m3_yq_ff[YQ_W-1 -: POS_W];
      r1 = r0 + POS_W'(1);
      r0c = (r0 < 0) ? POS_W'(0) : ((r0 > hx) ? hx : r0);
      r1c = (r1 < 0) ? POS_W'(0) : ((r1 > hx) ? hx : r1);
      col_left_in   = c0m[COORD_W-1:0];
      col_right_in  = c1m[COORD_W-1:0];
      row_top_in    = r0c[COORD_W-1:0];
      row_bottom_in = r1c[COORD_W-1:0];
   end

   logic [COORD_W-1:0]   col_left_ff, col_right_ff, row_top_ff, row_bottom_ff;
   logic [FRAC_BITS-1:0] frac_x_ff, frac_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= m3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         col_left_ff   <= col_left_in;
         col_right_ff  <= col_right_in;
         row_top_ff    <= row_top_in;
         row_bottom_ff <= row_bottom_in;
         frac_x_ff     <= m3_xq_ff[32:17];
         frac_y_ff     <= m3_yq_ff[31:16];
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.col_left   = col_left_ff;
   assign rsp.col_right  = col_right_ff;
   assign rsp.row_top    = row_top_ff;
   assign rsp.row_bottom = row_bottom_ff;
   assign rsp.frac_x     = frac_x_ff;
   assign rsp.frac_y     = frac_y_ff;

endmodule

FILE: sv/cte_div_cell.sv
// Divider cell: one restoring quotient bit for both texel components.
// Depends on cte_pkg.
module cte_div_cell import cte_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [REM_W-1:0] divisor,
   input  logic             in_valid,
   input  div_stage_type    in_stage,
   output logic             out_valid,
   output div_stage_type    out_stage
);

   logic          valid_ff;
   div_stage_type stage_ff;
   div_stage_type stage_in;

   function automatic div_lane_type div_step(div_lane_type l, logic [REM_W-1:0] d);
      logic [REM_W:0] sh;
      div_lane_type   r;
      sh = {l.rem, l.num[NUM_W-1]};
      r.num = {l.num[NUM_W-2:0], 1'b0};
      if (sh >= {1'b0, d}) begin
         r.rem = REM_W'(sh - {1'b0, d});
         r.quo = {l.quo[NUM_W-2:0], 1'b1};
      end else begin
         r.rem = sh[REM_W-1:0];
         r.quo = {l.quo[NUM_W-2:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      stage_in.face = in_stage.face;
      stage_in.a    = div_step(in_stage.a, divisor);
      stage_in.b    = div_step(in_stage.b, divisor);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

FILE: sv/cte_sqrt_cell.sv
// Square root cell: one root bit of the horizontal magnitude per cycle while en is high.
// Depends on cte_pkg.
module cte_sqrt_cell import cte_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  sqrt_stage_type in_stage,
   output logic           out_valid,
   output sqrt_stage_type out_stage
);

   logic           valid_ff;
   sqrt_stage_type stage_ff;
   sqrt_stage_type stage_in;
   logic [SREM_W-1:0] rem_sh;
   logic [SREM_W-1:0] trial;

   always_comb begin
      stage_in     = in_stage;
      rem_sh       = {in_stage.rem[SREM_W-3:0], in_stage.rad[RAD_W-1 -: 2]};
      trial        = SREM_W'({in_stage.root, 2'b01});
      stage_in.rad = {in_stage.rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         stage_in.rem  = rem_sh - trial;
         stage_in.root = {in_stage.root[ROOT_W-2:0], 1'b1};
      end else begin
         stage_in.rem  = rem_sh;
         stage_in.root = {in_stage.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

FILE: sv/cte_cordic_cell.sv
// CORDIC vectoring cell: one micro-rotation for the longitude and latitude lanes.
// Depends on cte_pkg (arctangent table).
module cte_cordic_cell import cte_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [STEP_W-1:0] step,
   input  logic              in_valid,
   input  cordic_stage_type  in_stage,
   output logic              out_valid,
   output cordic_stage_type  out_stage
);

   logic             valid_ff;
   cordic_stage_type stage_ff;
   cordic_stage_type stage_in;

   function automatic cordic_lane_type rotate(cordic_lane_type l, logic [STEP_W-1:0] s);
      logic signed [CV_W-1:0]  sx;
      logic signed [CV_W-1:0]  sy;
      logic signed [ANG_W-1:0] a;
      cordic_lane_type         r;
      sx = l.y >>> s;
      sy = l.x >>> s;
      a  = ATAN_TABLE[s];
      r  = l;
      if (l.y > 0) begin
         r.x = l.x + sx;
         r.y = l.y - sy;
         r.z = l.z + a;
      end else if (l.y < 0) begin
         r.x = l.x - sx;
         r.y = l.y + sy;
         r.z = l.z - a;
      end
      return r;
   endfunction

   always_comb begin
      stage_in.dir_ok = in_stage.dir_ok;
      stage_in.lon    = rotate(in_stage.lon, step);
      stage_in.lat    = rotate(in_stage.lat, step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

FILE: sv/cte_checker.sv
// Port-level checker for the cube texel to equirectangular sample block.
// Depends on cte_pkg; bound to cube_texel_to_equirect_sample_top.
module cte_checker import cte_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [COORD_W-1:0] col_left,
   input logic [COORD_W-1:0] col_right,
   input logic [COORD_W-1:0] row_top,
   input logic [COORD_W-1:0] row_bottom
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped under stall");

   a_cols: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((COORD_W+1)'(col_right) == (COORD_W+1)'(col_left) + 1'b1
                     || col_right == '0))
      else $error("right column not next to left");

   a_rows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (row_bottom == row_top
                     || (COORD_W+1)'(row_bottom) == (COORD_W+1)'(row_top) + 1'b1))
      else $error("bottom row not next to top");

endmodule

bind cube_texel_to_equirect_sample_top cte_checker u_cte_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .col_left   (rsp.col_left),
   .col_right  (rsp.col_right),
   .row_top    (rsp.row_top),
   .row_bottom (rsp.row_bottom)
);
